@@ hw/rtl/bblw_pkg.sv @@
`default_nettype none

package bblw_pkg;

	// Item kinds on the input channel
	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_STEP = 1'b1
	} mode_t;

	// Bitmap format register codes
	localparam logic FMT_HIRES = 1'b0;
	localparam logic FMT_MULTI = 1'b1;

	// Screen limits and layout
	localparam logic [8:0] HIRES_MAX_X  = 9'd319;
	localparam logic [8:0] MULTI_MAX_X  = 9'd159;
	localparam logic [7:0] SCREEN_MAX_Y = 8'd199;
	localparam logic [7:0] HIRES_MASK   = 8'h80;
	localparam logic [7:0] MULTI_MASK   = 8'hC0;
	localparam logic [7:0] KEEP_ALL     = 8'hFF;

	// Input word: one line command
	typedef struct packed {
		mode_t      mode;
		logic [8:0] x_start;
		logic [7:0] y_start;
		logic [8:0] x_end;
		logic [7:0] y_end;
		logic [1:0] color;
	} in_word_t;

	// Output word: one byte update
	typedef struct packed {
		logic [12:0] byte_offset;
		logic [7:0]  keep_mask;
		logic [7:0]  set_bits;
		logic        pixel_valid;
		logic        off_screen;
		logic        last;
	} out_word_t;

	// Word sent for a step that finds no active line
	function automatic out_word_t idle_word();
		out_word_t w;
		w.byte_offset = '0;
		w.keep_mask   = KEEP_ALL;
		w.set_bits    = '0;
		w.pixel_valid = 1'b0;
		w.off_screen  = 1'b0;
		w.last        = 1'b0;
		return w;
	endfunction

	// Byte address and masks for one pixel in cell order
	function automatic out_word_t pixel_word(
		input logic [8:0] x,
		input logic [7:0] y,
		input logic [1:0] col,
		input logic       fmt,
		input logic       fin
	);
		out_word_t   w;
		logic [8:0]  lim_x;
		logic [8:0]  px;
		logic [2:0]  sh;
		logic [12:0] row;
		logic [7:0]  bit_mask;
		logic [7:0]  pair_mask;
		lim_x     = (fmt == FMT_MULTI) ? MULTI_MAX_X : HIRES_MAX_X;
		px        = (fmt == FMT_MULTI) ? {x[7:0], 1'b0} : x;
		sh        = px[2:0];
		row       = 13'(y[7:3]);
		bit_mask  = HIRES_MASK >> sh;
		pair_mask = MULTI_MASK >> sh;
		w.pixel_valid = 1'b1;
		w.last        = fin;
		if ((x > lim_x) || (y > SCREEN_MAX_Y)) begin
			w.byte_offset = '0;
			w.keep_mask   = KEEP_ALL;
			w.set_bits    = '0;
			w.off_screen  = 1'b1;
		end else begin
			// row * 320 as two shifts
			w.byte_offset = (row << 8) + (row << 6) + 13'({px[8:3], 3'b000})
				+ 13'(y[2:0]);
			w.off_screen  = 1'b0;
			if (fmt == FMT_MULTI) begin
				w.keep_mask = ~pair_mask;
				w.set_bits  = {col, 6'b000000} >> sh;
			end else begin
				w.keep_mask = ~bit_mask;
				w.set_bits  = (col == 2'd1) ? bit_mask : 8'h00;
			end
		end
		return w;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bblw_stream_if.sv @@
`default_nettype none

interface bblw_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bresenham_bitmap_line_writer_unit.sv @@
// Bresenham line writer for a bitmap in 8x8 character-cell order.
// line_in carries command words (bblw_pkg::in_word_t). A load word latches
// both endpoints and the color and returns the first pixel; each step word
// returns the next pixel. Every accepted word gives exactly one word on
// pixel_out (bblw_pkg::out_word_t): byte offset, AND keep mask, OR set bits,
// plus pixel_valid, off_screen and last flags.
// cfg_we/cfg_wdata write the bitmap format (0 hires, 1 multicolor); write it
// only while no word is in flight.
// An accepted word is held in the input stage, then in the output stage.
// Throughput: one word per cycle while pixel_out.ready holds; the line state
// update (error add, coordinate step) is combinational, so steps add no stall.
// Two registers sit between the channels (input stage and output stage): when
// the receiver stalls, one more word is still taken, then line_in.ready drops.
// Reset (arst_n low) clears the format to hires, drops any active line and
// empties both stages; a step with no active line returns an idle word.
`default_nettype none

module bresenham_bitmap_line_writer_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic          cfg_wdata,
	bblw_stream_if.sink        line_in,
	bblw_stream_if.source      pixel_out
);

	typedef struct packed {
		logic x_moves;
		logic x_neg;
		logic y_moves;
		logic y_neg;
		logic x_fast;
	} signs_t;

	logic               fmt_q;

	// Input stage
	logic               v_s1;
	bblw_pkg::in_word_t in_s1;
	logic               fire_s1;

	// Line state
	logic [8:0]         cur_x_q, cur_x_d;
	logic [7:0]         cur_y_q, cur_y_d;
	logic signed [9:0]  err_q, err_d;
	logic [8:0]         steps_q, steps_d;
	logic [8:0]         short_q, short_d;
	logic [8:0]         long_q, long_d;
	signs_t             signs_q, signs_d;
	logic [1:0]         color_q, color_d;
	logic               active_q, active_d;

	// Output stage
	logic                out_v_q;
	bblw_pkg::out_word_t out_q;
	bblw_pkg::out_word_t res;

	// Load setup and step temporaries
	logic [8:0]         adx;
	logic [7:0]         ady;
	logic signed [9:0]  err_sub;

	assign fire_s1       = v_s1 && (!out_v_q || pixel_out.ready);
	assign line_in.ready = !v_s1 || fire_s1;
	assign pixel_out.valid = out_v_q;
	assign pixel_out.data  = out_q;

	// Format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= bblw_pkg::FMT_HIRES;
		end else if (cfg_we) begin
			fmt_q <= cfg_wdata;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (line_in.valid && line_in.ready) begin
				v_s1 <= 1'b1;
			end else if (fire_s1) begin
				v_s1 <= 1'b0;
			end
			if (fire_s1) begin
				out_v_q <= 1'b1;
			end else if (pixel_out.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (line_in.valid && line_in.ready) begin
			in_s1 <= line_in.data;
		end
		if (fire_s1) begin
			out_q <= res;
		end
	end

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			err_q    <= '0;
			steps_q  <= '0;
			short_q  <= '0;
			long_q   <= '0;
			signs_q  <= '0;
			color_q  <= '0;
			active_q <= 1'b0;
		end else if (fire_s1) begin
			cur_x_q  <= cur_x_d;
			cur_y_q  <= cur_y_d;
			err_q    <= err_d;
			steps_q  <= steps_d;
			short_q  <= short_d;
			long_q   <= long_d;
			signs_q  <= signs_d;
			color_q  <= color_d;
			active_q <= active_d;
		end
	end

	// Next line state and result word
	always_comb begin
		cur_x_d  = cur_x_q;
		cur_y_d  = cur_y_q;
		err_d    = err_q;
		steps_d  = steps_q;
		short_d  = short_q;
		long_d   = long_q;
		signs_d  = signs_q;
		color_d  = color_q;
		active_d = active_q;
		adx      = '0;
		ady      = '0;
		err_sub  = err_q - $signed({1'b0, short_q});
		res      = bblw_pkg::idle_word();

		unique case (in_s1.mode)
			bblw_pkg::MODE_LOAD: begin
				signs_d = '0;
				// spans and directions
				if (in_s1.x_end > in_s1.x_start) begin
					adx             = in_s1.x_end - in_s1.x_start;
					signs_d.x_moves = 1'b1;
				end else if (in_s1.x_end < in_s1.x_start) begin
					adx             = in_s1.x_start - in_s1.x_end;
					signs_d.x_moves = 1'b1;
					signs_d.x_neg   = 1'b1;
				end
				if (in_s1.y_end > in_s1.y_start) begin
					ady             = in_s1.y_end - in_s1.y_start;
					signs_d.y_moves = 1'b1;
				end else if (in_s1.y_end < in_s1.y_start) begin
					ady             = in_s1.y_start - in_s1.y_end;
					signs_d.y_moves = 1'b1;
					signs_d.y_neg   = 1'b1;
				end
				// tie goes to y as the fast axis
				if (adx > 9'(ady)) begin
					signs_d.x_fast = 1'b1;
					long_d         = adx;
					short_d        = 9'(ady);
				end else begin
					long_d  = 9'(ady);
					short_d = adx;
				end
				cur_x_d  = in_s1.x_start;
				cur_y_d  = in_s1.y_start;
				color_d  = in_s1.color;
				err_d    = $signed({2'b00, long_d[8:1]});
				steps_d  = long_d;
				active_d = (long_d != '0);
				res      = bblw_pkg::pixel_word(cur_x_d, cur_y_d, color_d, fmt_q,
					long_d == '0);
			end
			bblw_pkg::MODE_STEP: begin
				if (!active_q || (steps_q == '0)) begin
					active_d = 1'b0;
				end else begin
					priority if (err_sub < 0) begin
						// diagonal move
						err_d = err_sub + $signed({1'b0, long_q});
						if (signs_q.x_moves) begin
							cur_x_d = signs_q.x_neg ? cur_x_q - 9'd1 : cur_x_q + 9'd1;
						end
						if (signs_q.y_moves) begin
							cur_y_d = signs_q.y_neg ? cur_y_q - 8'd1 : cur_y_q + 8'd1;
						end
					end else if (signs_q.x_fast) begin
						err_d = err_sub;
						if (signs_q.x_moves) begin
							cur_x_d = signs_q.x_neg ? cur_x_q - 9'd1 : cur_x_q + 9'd1;
						end
					end else begin
						err_d = err_sub;
						if (signs_q.y_moves) begin
							cur_y_d = signs_q.y_neg ? cur_y_q - 8'd1 : cur_y_q + 8'd1;
						end
					end
					steps_d  = steps_q - 9'd1;
					active_d = (steps_d != '0);
					res      = bblw_pkg::pixel_word(cur_x_d, cur_y_d, color_q, fmt_q,
						steps_d == '0);
				end
			end
			default: begin
				res = bblw_pkg::idle_word();
			end
		endcase
	end

`ifndef SYNTHESIS
	// an active line always has steps to go
	a_active_steps: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (steps_q != '0))
		else $error("active line with no steps left");

	// error term stays within [0, long span) while a line runs
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (!err_q[9] && ($unsigned(err_q) < 10'(long_q))))
		else $error("error term out of range");

	// emitting the last pixel ends the line
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && res.last) |=> !active_q)
		else $error("line still active after last pixel");

	// set bits only land where the keep mask clears
	a_mask_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ((out_q.set_bits & out_q.keep_mask) == 8'h00))
		else $error("set bits overlap kept bits");

	// input stalls only when the input stage is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!line_in.ready |-> (v_s1 && out_v_q && !pixel_out.ready))
		else $error("input stalled without a held stage");
`endif

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 1650;
	localparam int FLIP_EVERY   = 250;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_EVERY4,
		RX_SPARSE
	} rx_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	bblw_stream_if #(.T(bblw_pkg::in_word_t))  line_if ();
	bblw_stream_if #(.T(bblw_pkg::out_word_t)) pix_if ();

	bresenham_bitmap_line_writer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.line_in   (line_if),
		.pixel_out (pix_if)
	);

	always #4 clk = ~clk;

	// Line walker state mirrored in the bench
	logic       fmt_reg;
	logic [8:0] walk_x;
	logic [7:0] walk_y;
	int         walk_err;
	logic [8:0] walk_left;
	logic [8:0] walk_short;
	logic [8:0] walk_long;
	logic       x_moves, x_neg, y_moves, y_neg, x_fast;
	logic [1:0] walk_color;
	logic       walk_active;

	bblw_pkg::out_word_t pending_pixels[$];

	int cycle_count = 0;
	int mismatches = 0;
	int words_checked = 0;
	int items_sent = 0;
	int loads_sent = 0;
	int steps_sent = 0;
	int idle_words = 0;
	int offscreen_words = 0;
	int fmt_writes = 0;
	int burst_left = 0;

	rx_style_t rx_style = RX_OPEN;
	int rx_hold = 0;

	initial begin
		line_if.valid = 1'b0;
		line_if.data  = '0;
		pix_if.ready  = 1'b0;
	end

	// Byte update for one pixel in cell order
	function automatic bblw_pkg::out_word_t raster_byte(input logic [8:0] x,
			input logic [7:0] y, input logic [1:0] col, input logic fin);
		bblw_pkg::out_word_t w;
		logic [8:0] lim;
		logic [9:0] px;
		logic [2:0] sh;
		int         ofs;
		lim = (fmt_reg == bblw_pkg::FMT_MULTI) ? bblw_pkg::MULTI_MAX_X
			: bblw_pkg::HIRES_MAX_X;
		w.pixel_valid = 1'b1;
		w.last = fin;
		if (x > lim || y > bblw_pkg::SCREEN_MAX_Y) begin
			w.byte_offset = '0;
			w.keep_mask   = bblw_pkg::KEEP_ALL;
			w.set_bits    = '0;
			w.off_screen  = 1'b1;
		end else begin
			px  = (fmt_reg == bblw_pkg::FMT_MULTI) ? {x, 1'b0} : {1'b0, x};
			sh  = px[2:0];
			ofs = int'(y[7:3]) * 320 + int'(px & 10'h3F8) + int'(y[2:0]);
			w.byte_offset = ofs[12:0];
			w.off_screen  = 1'b0;
			if (fmt_reg == bblw_pkg::FMT_MULTI) begin
				w.keep_mask = ~(bblw_pkg::MULTI_MASK >> sh);
				w.set_bits  = {col, 6'b000000} >> sh;
			end else begin
				w.keep_mask = ~(bblw_pkg::HIRES_MASK >> sh);
				w.set_bits  = (col == 2'd1) ? (bblw_pkg::HIRES_MASK >> sh) : 8'h00;
			end
		end
		return w;
	endfunction

	function automatic void move_x();
		if (x_moves)
			walk_x = x_neg ? walk_x - 9'd1 : walk_x + 9'd1;
	endfunction

	function automatic void move_y();
		if (y_moves)
			walk_y = y_neg ? walk_y - 8'd1 : walk_y + 8'd1;
	endfunction

	// Advance the mirrored walker by one word and return the expected output
	function automatic bblw_pkg::out_word_t predict_pixel(input bblw_pkg::in_word_t w);
		bblw_pkg::out_word_t r;
		logic [8:0] adx;
		logic [8:0] ady;
		if (w.mode == bblw_pkg::MODE_LOAD) begin
			x_moves = (w.x_end != w.x_start);
			x_neg   = (w.x_end < w.x_start);
			adx     = x_neg ? w.x_start - w.x_end : w.x_end - w.x_start;
			y_moves = (w.y_end != w.y_start);
			y_neg   = (w.y_end < w.y_start);
			ady     = y_neg ? 9'(w.y_start - w.y_end) : 9'(w.y_end - w.y_start);
			// equal spans make y the fast axis
			x_fast     = (adx > ady);
			walk_long  = x_fast ? adx : ady;
			walk_short = x_fast ? ady : adx;
			walk_x     = w.x_start;
			walk_y     = w.y_start;
			walk_color = w.color;
			walk_err   = int'(walk_long >> 1);
			walk_left  = walk_long;
			walk_active = (walk_left != 0);
			return raster_byte(walk_x, walk_y, walk_color, walk_left == 0);
		end
		if (!walk_active || walk_left == 0) begin
			walk_active = 1'b0;
			r.byte_offset = '0;
			r.keep_mask   = bblw_pkg::KEEP_ALL;
			r.set_bits    = '0;
			r.pixel_valid = 1'b0;
			r.off_screen  = 1'b0;
			r.last        = 1'b0;
			return r;
		end
		walk_err = walk_err - int'(walk_short);
		if (walk_err < 0) begin
			walk_err = walk_err + int'(walk_long);
			move_x();
			move_y();
		end else if (x_fast) begin
			move_x();
		end else begin
			move_y();
		end
		walk_left = walk_left - 9'd1;
		if (walk_left == 0)
			walk_active = 1'b0;
		return raster_byte(walk_x, walk_y, walk_color, walk_left == 0);
	endfunction

	task automatic report_field(input string name, input int e, input int a);
		if (e != a) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, e, a);
			mismatches++;
		end
	endtask

	task automatic check_word(input bblw_pkg::out_word_t got);
		bblw_pkg::out_word_t e;
		if (pending_pixels.size() == 0) begin
			$display("%0t ns: unexpected word 0x%0h, expected nothing", $time, got);
			mismatches++;
		end else begin
			e = pending_pixels.pop_front();
			words_checked++;
			report_field("byte_offset", e.byte_offset, got.byte_offset);
			report_field("keep_mask", e.keep_mask, got.keep_mask);
			report_field("set_bits", e.set_bits, got.set_bits);
			report_field("pixel_valid", e.pixel_valid, got.pixel_valid);
			report_field("off_screen", e.off_screen, got.off_screen);
			report_field("last", e.last, got.last);
		end
	endtask

	// Output check and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n && pix_if.valid && pix_if.ready)
			check_word(pix_if.data);
		if (rx_hold == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 3));
			rx_hold  = $urandom_range(20, 200);
		end else begin
			rx_hold--;
		end
		case (rx_style)
			RX_OPEN:   pix_if.ready <= 1'b1;
			RX_COIN:   pix_if.ready <= 1'($urandom_range(0, 1));
			RX_EVERY4: pix_if.ready <= (cycle_count % 4 == 0);
			default:   pix_if.ready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Sender bursts with random gaps; some bursts run back to back
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				line_if.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	task automatic send_word(input bblw_pkg::in_word_t w);
		line_if.valid <= 1'b1;
		line_if.data  <= w;
		@(posedge clk);
		while (!line_if.ready) @(posedge clk);
		pending_pixels.push_back(predict_pixel(w));
		items_sent++;
		if (w.mode == bblw_pkg::MODE_LOAD) begin
			loads_sent++;
		end else begin
			steps_sent++;
		end
		if (pending_pixels[$].off_screen) offscreen_words++;
		if (!pending_pixels[$].pixel_valid) idle_words++;
		pace_sender();
	endtask

	// Hold off input until every expected word has arrived
	task automatic drain_pixels();
		line_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic set_format(input logic v);
		drain_pixels();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		fmt_reg = v;
		fmt_writes++;
	endtask

	function automatic bblw_pkg::in_word_t load_word(input int xs, input int ys,
			input int xe, input int ye, input int col);
		bblw_pkg::in_word_t w;
		w.mode    = bblw_pkg::MODE_LOAD;
		w.x_start = xs[8:0];
		w.y_start = ys[7:0];
		w.x_end   = xe[8:0];
		w.y_end   = ye[7:0];
		w.color   = col[1:0];
		return w;
	endfunction

	// Step words carry junk in the unused fields
	function automatic bblw_pkg::in_word_t step_word();
		bblw_pkg::in_word_t w;
		w.mode    = bblw_pkg::MODE_STEP;
		w.x_start = 9'($urandom_range(0, 511));
		w.y_start = 8'($urandom_range(0, 255));
		w.x_end   = 9'($urandom_range(0, 511));
		w.y_end   = 8'($urandom_range(0, 255));
		w.color   = 2'($urandom_range(0, 3));
		return w;
	endfunction

	task automatic send_steps(input int n);
		for (int i = 0; i < n; i++)
			send_word(step_word());
	endtask

	function automatic int clip(input int v, input int hi);
		return (v < 0) ? 0 : ((v > hi) ? hi : v);
	endfunction

	function automatic int line_span(input bblw_pkg::in_word_t w);
		int dx;
		int dy;
		dx = int'(w.x_end) - int'(w.x_start);
		dy = int'(w.y_end) - int'(w.y_start);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return (dx > dy) ? dx : dy;
	endfunction

	task automatic test_step_without_line();
		send_steps(1);
	endtask

	task automatic test_single_points();
		send_word(load_word(0, 0, 0, 0, 1));
		send_word(load_word(319, 199, 319, 199, 1));
		// beyond every limit: nothing written
		send_word(load_word(511, 255, 511, 255, 3));
	endtask

	task automatic test_hires_lines();
		// shallow line, then one step past its end
		send_word(load_word(0, 0, 5, 2, 1));
		send_steps(6);
		// long line dropped early by a new load
		send_word(load_word(0, 0, 319, 199, 0));
		send_steps(2);
		// tie of spans, both coordinates falling
		send_word(load_word(10, 10, 6, 6, 2));
		send_steps(2);
	endtask

	task automatic test_multicolor_lines();
		set_format(bblw_pkg::FMT_MULTI);
		// crosses the multicolor x limit
		send_word(load_word(150, 100, 170, 97, 2));
		send_steps(3);
		// format flips while the line is running
		send_word(load_word(159, 199, 0, 0, 3));
		send_steps(1);
		set_format(bblw_pkg::FMT_HIRES);
		send_steps(2);
	endtask

	task automatic test_random_lines();
		bblw_pkg::in_word_t w;
		int       r;
		int       xs, ys, xe, ye;
		int       n_steps;
		int       flip_at;
		int       stop_at;
		int       next_flip;
		stop_at   = items_sent + RANDOM_ITEMS;
		next_flip = items_sent + FLIP_EVERY;
		set_format(bblw_pkg::FMT_MULTI);
		while (items_sent < stop_at) begin
			if (items_sent >= next_flip) begin
				set_format(~fmt_reg);
				next_flip = items_sent + FLIP_EVERY;
			end
			r = $urandom_range(0, 99);
			if (r < 6) begin
				// stray steps, mostly with no line behind them
				send_steps($urandom_range(1, 3));
				continue;
			end
			r = $urandom_range(0, 99);
			if (r < 70) begin
				xs = $urandom_range(0, 319);
				if (fmt_reg == bblw_pkg::FMT_MULTI && $urandom_range(0, 1) == 1)
					xs = $urandom_range(0, 175);
				ys = $urandom_range(0, 199);
				xe = clip(xs + int'($urandom_range(0, 40)) - 20, 319);
				ye = clip(ys + int'($urandom_range(0, 40)) - 20, 199);
			end else if (r < 82) begin
				xs = $urandom_range(0, 319);
				ys = $urandom_range(0, 199);
				xe = $urandom_range(0, 319);
				ye = $urandom_range(0, 199);
			end else if (r < 92) begin
				xs = $urandom_range(0, 1) * 319;
				ys = $urandom_range(0, 1) * 199;
				xe = $urandom_range(0, 1) * 319;
				ye = $urandom_range(0, 1) * 199;
			end else begin
				// coordinates past the screen
				xs = $urandom_range(0, 511);
				ys = $urandom_range(0, 255);
				xe = clip(xs + int'($urandom_range(0, 60)) - 30, 511);
				ye = clip(ys + int'($urandom_range(0, 60)) - 30, 255);
			end
			w = load_word(xs, ys, xe, ye, $urandom_range(0, 3));
			send_word(w);
			r = $urandom_range(0, 99);
			if (r < 80) begin
				n_steps = line_span(w) + $urandom_range(0, 2);
			end else begin
				n_steps = $urandom_range(0, line_span(w));
			end
			flip_at = ($urandom_range(0, 24) == 0) ? n_steps / 2 : -1;
			for (int i = 0; i < n_steps; i++) begin
				if (i == flip_at)
					set_format(~fmt_reg);
				send_word(step_word());
			end
		end
	endtask

	initial begin
		fmt_reg = bblw_pkg::FMT_HIRES;
		walk_x = '0;
		walk_y = '0;
		walk_err = 0;
		walk_left = '0;
		walk_short = '0;
		walk_long = '0;
		x_moves = 1'b0;
		x_neg = 1'b0;
		y_moves = 1'b0;
		y_neg = 1'b0;
		x_fast = 1'b0;
		walk_color = '0;
		walk_active = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_step_without_line();
		test_single_points();
		test_hires_lines();
		test_multicolor_lines();
		test_random_lines();

		drain_pixels();
		repeat (8) @(posedge clk);
		$display("Ran %0d loads and %0d steps over %0d format writes", loads_sent,
			steps_sent, fmt_writes);
		$display("%0d words checked: %0d off-screen, %0d idle, %0d mismatches",
			words_checked, offscreen_words, idle_words, mismatches);
		if (mismatches == 0 && pending_pixels.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/bblw_pkg.sv
hw/rtl/bblw_stream_if.sv
hw/rtl/bresenham_bitmap_line_writer_unit.sv
sim/testbench.sv
